@@ sv/vpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpl_pkg
// Types, register indexes and the divider step shared by the point locator.
// ----------------------------------------------------------------------------
package vpl_pkg;

    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam int          QUOT_W      = 32;
    localparam int          DIV_BITS    = 2;
    localparam int          DIV_STAGES  = QUOT_W / DIV_BITS;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_FAR_X    = 3'd3,
        REG_FAR_Y    = 3'd4,
        REG_FAR_Z    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic               inside_res;
        logic [62:0]        distance_sq;
        logic signed [31:0] closest_x;
        logic signed [31:0] closest_y;
        logic signed [31:0] closest_z;
        logic signed [31:0] param_r;
        logic signed [31:0] param_s;
        logic signed [31:0] param_t;
        logic [2:0]         weight_index;
        logic [16:0]        weight;
        logic               last;
    } result_t;

    // One axis of the long division: partial remainder, numerator bits still
    // to shift in (quotient bits shift in at the bottom), divisor magnitude and flags.
    typedef struct packed {
        logic [32:0]       rem;
        logic [QUOT_W-1:0] nq;
        logic [32:0]       dm;
        logic              neg;
        logic              sat;
        logic              zoff;
    } div_axis_t;

    // Data carried alongside the divider.
    typedef struct packed {
        logic [2:0][31:0] pt;
        logic [2:0][31:0] org;
        logic [2:0][32:0] ext;
    } side_t;

    // One restoring step: shift in a numerator bit, subtract if it fits.
    function automatic div_axis_t div_step(input div_axis_t a);
        div_axis_t   r;
        logic [33:0] t;
        logic [33:0] d;
        r = a;
        t = {a.rem, a.nq[QUOT_W-1]};
        d = {1'b0, a.dm};
        if (t >= d)
        begin
            r.rem = 33'(t - d);
            r.nq  = {a.nq[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[32:0];
            r.nq  = {a.nq[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/voxel_point_locate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_point_locate
// Locates a Q16.16 point against an axis-aligned box and emits eight
// trilinear corner weights with distance, closest point and parameters.
// ----------------------------------------------------------------------------
// Pipeline: input register, 17 divider stages, 5 arithmetic stages, hold
//   and output register between input transfer and the first result.
// Throughput: set by the eight-beat serialiser on the result channel; the
//   pipeline itself takes a point every cycle unless the hold stage stalls it.
// Reset: box registers return to the unit box, all stages empty; no sweep.
module voxel_point_locate (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [2:0]        wr_index,
    input  wire logic [31:0]       wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vpl_pkg::point_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vpl_pkg::result_t       out_data
);
    import vpl_pkg::*;

    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    // Box registers
    logic [31:0] origin_reg [3];
    logic [31:0] far_reg    [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a] <= '0;
                far_reg[a]    <= 32'(ONE_Q16);
            end
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_ORIGIN_X: origin_reg[0] <= wr_data;
                REG_ORIGIN_Y: origin_reg[1] <= wr_data;
                REG_ORIGIN_Z: origin_reg[2] <= wr_data;
                REG_FAR_X:    far_reg[0]    <= wr_data;
                REG_FAR_Y:    far_reg[1]    <= wr_data;
                REG_FAR_Z:    far_reg[2]    <= wr_data;
                default:      ;
            endcase
        end
    end

    // Global advance: the whole pipe moves unless its last stage is stuck
    logic en;
    logic hold_take;
    logic load;
    logic ss_valid_reg;
    logic hold_valid_reg;
    logic [2:0] beat_reg;

    assign en       = !ss_valid_reg || hold_take;
    assign in_ready = en;

    // Stage 0: offsets and extents
    logic        s0_valid_reg;
    side_t       s0_side_reg;
    logic [32:0] s0_off_reg [3];
    logic [31:0] pt_in [3];

    assign pt_in[0] = in_data.point_x;
    assign pt_in[1] = in_data.point_y;
    assign pt_in[2] = in_data.point_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s0_side_reg.pt[a]  <= pt_in[a];
                s0_side_reg.org[a] <= origin_reg[a];
                s0_side_reg.ext[a] <= $signed({far_reg[a][31], far_reg[a]})
                                    - $signed({origin_reg[a][31], origin_reg[a]});
                s0_off_reg[a]      <= $signed({pt_in[a][31], pt_in[a]})
                                    - $signed({origin_reg[a][31], origin_reg[a]});
            end
        end
    end

    // Divider set-up: magnitudes, sign and the quotient-overflow test
    div_axis_t div_init [3];

    always_comb
    begin
        logic [32:0] offm;
        logic [48:0] nm;
        logic [32:0] dm;
        logic [32:0] ext;
        for (int a = 0; a < 3; a++)
        begin
            ext  = s0_side_reg.ext[a];
            offm = s0_off_reg[a][32] ? 33'(-s0_off_reg[a]) : s0_off_reg[a];
            dm   = ext[32] ? 33'(-ext) : ext;
            nm   = {offm, 16'h0000};
            div_init[a].rem  = {16'h0000, nm[48:32]};
            div_init[a].nq   = nm[31:0];
            div_init[a].dm   = dm;
            div_init[a].neg  = s0_off_reg[a][32] ^ ext[32];
            div_init[a].sat  = ({16'h0000, nm[48:32]} >= dm);
            div_init[a].zoff = (s0_off_reg[a] == '0);
        end
    end

    // Divider pipeline, DIV_BITS quotient bits per stage
    logic      dv_valid_reg [DIV_STAGES+1];
    div_axis_t dv_reg       [DIV_STAGES+1][3];
    side_t     dv_side_reg  [DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        div_axis_t w;
        if (en)
        begin
            dv_side_reg[0] <= s0_side_reg;
            for (int a = 0; a < 3; a++)
                dv_reg[0][a] <= div_init[a];
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                dv_side_reg[s] <= dv_side_reg[s-1];
                for (int a = 0; a < 3; a++)
                begin
                    w = dv_reg[s-1][a];
                    for (int b = 0; b < DIV_BITS; b++)
                        w = div_step(w);
                    dv_reg[s][a] <= w;
                end
            end
        end
    end

    // Parameter stage: floor, saturation, inside test, clamp
    logic        sp_valid_reg;
    side_t       sp_side_reg;
    logic [31:0] sp_par_reg [3];
    logic [16:0] sp_pc_reg  [3];
    logic        sp_in_reg;
    logic [31:0] par_c [3];
    logic [16:0] pc_c  [3];
    logic        in_c  [3];

    always_comb
    begin
        div_axis_t   d;
        logic [32:0] v;
        for (int a = 0; a < 3; a++)
        begin
            d = dv_reg[DIV_STAGES][a];
            v = {1'b0, d.nq} + {32'h0, (d.rem != '0)};
            if (d.zoff)
                par_c[a] = '0;
            else if (d.sat)
                par_c[a] = d.neg ? PMIN : PMAX;
            else if (!d.neg)
                par_c[a] = d.nq[31] ? PMAX : d.nq;
            else
                par_c[a] = (v > 33'h080000000) ? PMIN : 32'(-v);
            in_c[a] = !par_c[a][31] && (par_c[a] <= 32'(ONE_Q16));
            if (par_c[a][31])
                pc_c[a] = '0;
            else if (par_c[a] > 32'(ONE_Q16))
                pc_c[a] = ONE_Q16;
            else
                pc_c[a] = par_c[a][16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_side_reg <= dv_side_reg[DIV_STAGES];
            sp_in_reg   <= in_c[0] && in_c[1] && in_c[2];
            for (int a = 0; a < 3; a++)
            begin
                sp_par_reg[a] <= par_c[a];
                sp_pc_reg[a]  <= pc_c[a];
            end
        end
    end

    // Multiply stage: closest-point products and the r*s corner products
    logic        sm_valid_reg;
    side_t       sm_side_reg;
    logic [31:0] sm_par_reg [3];
    logic [16:0] sm_pt_reg;
    logic        sm_in_reg;
    logic [50:0] sm_pe_reg [3];
    logic [33:0] sm_rs_reg [4];

    always_ff @(posedge clk)
    begin
        logic [16:0] fr [2];
        logic [16:0] fs [2];
        if (en)
        begin
            sm_side_reg <= sp_side_reg;
            sm_in_reg   <= sp_in_reg;
            sm_pt_reg   <= sp_pc_reg[2];
            fr[0] = ONE_Q16 - sp_pc_reg[0];
            fr[1] = sp_pc_reg[0];
            fs[0] = ONE_Q16 - sp_pc_reg[1];
            fs[1] = sp_pc_reg[1];
            for (int j = 0; j < 4; j++)
                sm_rs_reg[j] <= fr[j % 2] * fs[j / 2];
            for (int a = 0; a < 3; a++)
            begin
                sm_par_reg[a] <= sp_par_reg[a];
                sm_pe_reg[a]  <= 51'($signed({1'b0, sp_pc_reg[a]})
                                   * $signed(sp_side_reg.ext[a]));
            end
        end
    end

    // Closest-point stage: round to Q16.16, pick point when inside, difference
    logic        sc_valid_reg;
    logic [31:0] sc_close_reg [3];
    logic [32:0] sc_mag_reg   [3];
    logic [31:0] sc_par_reg   [3];
    logic [16:0] sc_pt_reg;
    logic        sc_in_reg;
    logic [33:0] sc_rs_reg    [4];

    always_ff @(posedge clk)
    begin
        logic signed [51:0] rnd;
        logic signed [51:0] cb;
        logic [31:0]        cl;
        logic signed [32:0] df;
        if (en)
        begin
            sc_in_reg <= sm_in_reg;
            sc_pt_reg <= sm_pt_reg;
            sc_rs_reg <= sm_rs_reg;
            for (int a = 0; a < 3; a++)
            begin
                rnd = $signed({sm_pe_reg[a][50], sm_pe_reg[a]}) + 52'sd32768;
                cb  = $signed({{20{sm_side_reg.org[a][31]}}, sm_side_reg.org[a]})
                    + (rnd >>> 16);
                cl  = sm_in_reg ? sm_side_reg.pt[a] : cb[31:0];
                df  = $signed({cl[31], cl})
                    - $signed({sm_side_reg.pt[a][31], sm_side_reg.pt[a]});
                sc_close_reg[a] <= cl;
                sc_mag_reg[a]   <= df[32] ? 33'(-df) : df;
                sc_par_reg[a]   <= sm_par_reg[a];
            end
        end
    end

    // Square stage
    logic        sq_valid_reg;
    logic [64:0] sq_sq_reg    [3];
    logic [31:0] sq_close_reg [3];
    logic [31:0] sq_par_reg   [3];
    logic [16:0] sq_pt_reg;
    logic        sq_in_reg;
    logic [33:0] sq_rs_reg    [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_in_reg    <= sc_in_reg;
            sq_pt_reg    <= sc_pt_reg;
            sq_rs_reg    <= sc_rs_reg;
            sq_close_reg <= sc_close_reg;
            sq_par_reg   <= sc_par_reg;
            for (int a = 0; a < 3; a++)
                sq_sq_reg[a] <= 65'(sc_mag_reg[a] * sc_mag_reg[a]);
        end
    end

    // Sum stage: saturating distance
    logic [62:0] ss_dist_reg;
    logic [31:0] ss_close_reg [3];
    logic [31:0] ss_par_reg   [3];
    logic [16:0] ss_pt_reg;
    logic        ss_in_reg;
    logic [33:0] ss_rs_reg    [4];

    always_ff @(posedge clk)
    begin
        logic [66:0] tot;
        if (en)
        begin
            tot = {2'b00, sq_sq_reg[0]} + {2'b00, sq_sq_reg[1]} + {2'b00, sq_sq_reg[2]};
            if (sq_in_reg)
                ss_dist_reg <= '0;
            else if (tot[66:63] != '0)
                ss_dist_reg <= '1;
            else
                ss_dist_reg <= tot[62:0];
            ss_in_reg    <= sq_in_reg;
            ss_pt_reg    <= sq_pt_reg;
            ss_rs_reg    <= sq_rs_reg;
            ss_close_reg <= sq_close_reg;
            ss_par_reg   <= sq_par_reg;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++)
                dv_valid_reg[s] <= 1'b0;
            sp_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            ss_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            dv_valid_reg[0] <= s0_valid_reg;
            for (int s = 1; s <= DIV_STAGES; s++)
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            sp_valid_reg <= dv_valid_reg[DIV_STAGES];
            sm_valid_reg <= sp_valid_reg;
            sc_valid_reg <= sm_valid_reg;
            sq_valid_reg <= sc_valid_reg;
            ss_valid_reg <= sq_valid_reg;
        end
    end

    // Hold stage and eight-beat serialiser. The output register parts the
    // result side from the pipe, so a waiting transfer never blocks a load
    // once the consumer takes it.
    logic [62:0] hd_dist_reg;
    logic [31:0] hd_close_reg [3];
    logic [31:0] hd_par_reg   [3];
    logic [16:0] hd_pt_reg;
    logic        hd_in_reg;
    logic [33:0] hd_rs_reg    [4];
    logic        out_valid_reg;
    result_t     out_data_reg;

    assign load      = hold_valid_reg && (!out_valid_reg || out_ready);
    assign hold_take = !hold_valid_reg || (load && (beat_reg == 3'd7));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            beat_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (hold_take)
            begin
                hold_valid_reg <= ss_valid_reg;
                beat_reg       <= '0;
            end
            else if (load)
                beat_reg <= beat_reg + 3'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [16:0] ft;
        logic [50:0] wp;
        if (hold_take)
        begin
            hd_dist_reg  <= ss_dist_reg;
            hd_close_reg <= ss_close_reg;
            hd_par_reg   <= ss_par_reg;
            hd_pt_reg    <= ss_pt_reg;
            hd_in_reg    <= ss_in_reg;
            hd_rs_reg    <= ss_rs_reg;
        end
        if (load)
        begin
            // weight = rs product times the t factor, rounded half up to Q1.16
            ft = beat_reg[2] ? hd_pt_reg : 17'(ONE_Q16 - hd_pt_reg);
            wp = 51'(hd_rs_reg[beat_reg[1:0]] * ft) + 51'h000080000000;
            out_data_reg.inside_res   <= hd_in_reg;
            out_data_reg.distance_sq  <= hd_dist_reg;
            out_data_reg.closest_x    <= hd_close_reg[0];
            out_data_reg.closest_y    <= hd_close_reg[1];
            out_data_reg.closest_z    <= hd_close_reg[2];
            out_data_reg.param_r      <= hd_par_reg[0];
            out_data_reg.param_s      <= hd_par_reg[1];
            out_data_reg.param_t      <= hd_par_reg[2];
            out_data_reg.weight_index <= beat_reg;
            out_data_reg.weight       <= hd_in_reg ? wp[48:32] : '0;
            out_data_reg.last         <= (beat_reg == 3'd7);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (hold_valid_reg && ss_valid_reg))
        else $error("input stalled without a blocked item");

    a_inside_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.inside_res) |-> (out_data.distance_sq == '0))
        else $error("inside point with non-zero distance");

    a_beat_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (beat_reg == 3'd7)) |=> (!hold_valid_reg || (beat_reg == 3'd0)))
        else $error("serialiser did not restart after the eighth beat");

endmodule
`default_nettype wire
